// File: rtl/vtu_pkg.sv
// Shared widths, codes and pipeline types of the vertex transform unit.
package vtu_pkg;

	localparam int QW     = 32;          // quotient bits formed by the divider
	localparam int ACC_W  = 66;          // full-width dot product accumulator
	localparam int MAG_W  = 64;          // magnitude of an accumulator
	localparam int NUM_W  = MAG_W + 16;  // numerator scaled to Q16.16
	localparam int REM_W  = MAG_W + QW;  // divider partial remainder
	localparam int NREG   = 8;
	localparam int ADDR_W = 6;

	localparam logic [1:0] OP_AFFINE = 2'd0;
	localparam logic [1:0] OP_PERSP  = 2'd1;
	localparam logic [1:0] OP_NORMAL = 2'd2;
	localparam logic [1:0] OP_SPARE  = 2'd3;  // unused code, handled as affine

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_WZERO = 2'd2;

	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	// one component of the perspective divide
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QW-1:0]    q;
		logic             neg;
		logic             ovf;
	} dlane_t;

	// payload of the divider stages; non-divide results ride along
	typedef struct packed {
		dlane_t [2:0]      ln;
		logic [MAG_W-1:0]  den;
		logic              use_div;
		logic [2:0][31:0]  rnd;
		logic [1:0]        pst;
	} dstage_t;

endpackage

// File: rtl/vtu_if.sv
// Handshake channels of the vertex transform unit: input item and result item.
interface vtu_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic signed [31:0] vx;
	logic signed [31:0] vy;
	logic signed [31:0] vz;
	modport source (output valid, op, vx, vy, vz, input ready);
	modport sink   (input valid, op, vx, vy, vz, output ready);
endinterface

interface vtu_out_if;
	logic              valid;
	logic              ready;
	logic signed [31:0] rx;
	logic signed [31:0] ry;
	logic signed [31:0] rz;
	logic [1:0]        status;
	modport source (output valid, rx, ry, rz, status, input ready);
	modport sink   (input valid, rx, ry, rz, status, output ready);
endinterface

// File: rtl/vtu_div_bit.sv
// One restoring divide step: resolves a single quotient bit.
module vtu_div_bit import vtu_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  dlane_t           li,
	input  logic [MAG_W-1:0] den,
	output dlane_t           lo
);
	logic [REM_W-1:0] dsh;
	logic [REM_W-1:0] diff;

	assign dsh  = {{QW{1'b0}}, den} << SHIFT;
	assign diff = li.rem - dsh;

	always_comb begin
		lo = li;
		if (li.rem >= dsh) begin
			lo.rem       = diff;
			lo.q[SHIFT]  = 1'b1;
		end
	end
endmodule

// File: rtl/vertex_transform_unit_core.sv
// Top level: pipelined 4x4 homogeneous vertex transform with perspective divide.
// Path from input accept to result valid: 36 register stages (multiply,
//   sum, prepare, 32 divide steps, round into the output register); every op takes
//   the same path; the one-bit-per-stage divider sets the depth.
// Throughput: one item per cycle while the skid register is empty.
// A skid register behind the output lets a stalled result wait without loss.
// Reset (arst_n low, async): pipeline empty, matrix registers set to identity.
module vertex_transform_unit_core import vtu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	vtu_in_if.sink            vtx_in,
	vtu_out_if.source         vtx_out
);
	localparam int NST = QW + 3;   // s1, s2, divider stages 0..QW

	// ---------------- matrix registers ----------------
	logic [63:0] cfg_q [NREG];
	logic [2:0]  cfg_idx;

	assign cfg_idx = paddr[5:3];
	assign pready  = 1'b1;
	assign prdata  = cfg_q[cfg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= 64'h0000_0000_0001_0000;
			cfg_q[1] <= 64'h0;
			cfg_q[2] <= 64'h0001_0000_0000_0000;
			cfg_q[3] <= 64'h0;
			cfg_q[4] <= 64'h0;
			cfg_q[5] <= 64'h0000_0000_0001_0000;
			cfg_q[6] <= 64'h0;
			cfg_q[7] <= 64'h0001_0000_0000_0000;
		end else if (psel && penable && pwrite) begin
			cfg_q[cfg_idx] <= pwdata;
		end
	end

	// element [row][col]; columns 1,3 in the low word, 2,4 in the high word
	logic signed [31:0] mat [4][4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mat[r][c] = (c % 2 == 1) ? cfg_q[r*2 + c/2][63:32] : cfg_q[r*2 + c/2][31:0];
			end
		end
	end

	// ---------------- flow control ----------------
	// The whole pipe moves together; it halts only when the skid register is full.
	logic           en;
	logic [NST-1:0] vld_s;
	logic           out_v_q, skid_v_q;
	logic           take, push;

	assign en           = !skid_v_q;
	assign vtx_in.ready = en;
	assign take         = out_v_q && vtx_out.ready;
	assign push         = en && vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], vtx_in.valid};
		end
	end

	// ---------------- s1: products ----------------
	logic signed [63:0] prod_s1  [3][4];
	logic signed [31:0] trans_s1 [4];
	logic [1:0]         op_s1;
	logic signed [31:0] vin [3];

	assign vin[0] = vtx_in.vx;
	assign vin[1] = vtx_in.vy;
	assign vin[2] = vtx_in.vz;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= vtx_in.op;
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 3; r++) begin
					prod_s1[r][c] <= vin[r] * mat[r][c];
				end
				// normals skip the translation row
				trans_s1[c] <= (vtx_in.op == OP_NORMAL) ? 32'sd0 : mat[3][c];
			end
		end
	end

	// ---------------- s2: full-width sums ----------------
	logic signed [ACC_W-1:0] acc_s2 [4];
	logic [1:0]              op_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			for (int c = 0; c < 4; c++) begin
				acc_s2[c] <= ACC_W'(prod_s1[0][c]) + ACC_W'(prod_s1[1][c])
				           + ACC_W'(prod_s1[2][c])
				           + ACC_W'($signed({trans_s1[c], 16'h0000}));
			end
		end
	end

	// ---------------- s3: round, or set up the divide ----------------
	dstage_t dv_s [QW+1];
	dstage_t prep;

	always_comb begin
		logic signed [ACC_W-1:0] t;
		logic [ACC_W-17:0]       sh;
		logic                    any_sat, wzero, fits;
		logic [ACC_W-1:0]        mag;
		logic [MAG_W-1:0]        den;
		logic [NUM_W-1:0]        num;
		logic [31:0]             rv, wzv;

		any_sat = 1'b0;
		wzero   = (acc_s2[3] == '0);
		mag     = acc_s2[3][ACC_W-1] ? ACC_W'(-acc_s2[3]) : acc_s2[3];
		den     = mag[MAG_W-1:0];
		prep    = '0;
		prep.den = den;
		prep.use_div = (op_s2 == OP_PERSP) && !wzero;
		for (int c = 0; c < 3; c++) begin
			// Q32.32 to Q16.16, ties toward +infinity, saturate
			t    = acc_s2[c] + ACC_W'(32768);
			sh   = t[ACC_W-1:16];
			fits = (&sh[ACC_W-17:31]) || !(|sh[ACC_W-17:31]);
			rv   = fits ? sh[31:0] : (sh[ACC_W-17] ? Q_MIN : Q_MAX);
			if (!fits) any_sat = 1'b1;
			// zero w: saturate toward the sign of the numerator
			wzv  = (acc_s2[c] == '0) ? 32'h0 : (acc_s2[c][ACC_W-1] ? Q_MIN : Q_MAX);
			prep.rnd[c] = (op_s2 == OP_PERSP) ? wzv : rv;
			// divide set-up on magnitudes
			mag  = acc_s2[c][ACC_W-1] ? ACC_W'(-acc_s2[c]) : acc_s2[c];
			num  = {mag[MAG_W-1:0], 16'h0000};
			prep.ln[c].rem = REM_W'(num);
			prep.ln[c].q   = '0;
			prep.ln[c].neg = acc_s2[c][ACC_W-1] ^ acc_s2[3][ACC_W-1];
			// quotient of 2^QW or more always saturates
			prep.ln[c].ovf = REM_W'(num) >= {den, {QW{1'b0}}};
		end
		if (op_s2 == OP_PERSP) prep.pst = wzero ? ST_WZERO : ST_OK;
		else                   prep.pst = any_sat ? ST_SAT : ST_OK;
	end

	// ---------------- divider: one quotient bit per stage ----------------
	dstage_t dv_nx [QW+1];
	assign dv_nx[0] = prep;

	for (genvar k = 1; k <= QW; k++) begin : g_div
		dlane_t lo [3];
		for (genvar j = 0; j < 3; j++) begin : g_lane
			vtu_div_bit #(.SHIFT(QW - k)) u_bit (
				.li  (dv_s[k-1].ln[j]),
				.den (dv_s[k-1].den),
				.lo  (lo[j])
			);
		end
		always_comb begin
			dv_nx[k]       = dv_s[k-1];
			dv_nx[k].ln[0] = lo[0];
			dv_nx[k].ln[1] = lo[1];
			dv_nx[k].ln[2] = lo[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= QW; k++) dv_s[k] <= dv_nx[k];
		end
	end

	// ---------------- final rounding of the quotient ----------------
	logic [2:0][31:0] res_val;
	logic [1:0]       res_st;

	always_comb begin
		dlane_t      l;
		logic        up, sat, any_sat;
		logic [QW:0] q1, lim;

		any_sat = 1'b0;
		for (int c = 0; c < 3; c++) begin
			l   = dv_s[QW].ln[c];
			// remainder below den: half-way test on one extra bit
			up  = {l.rem[MAG_W-1:0], 1'b0} >= {1'b0, dv_s[QW].den};
			q1  = {1'b0, l.q} + (QW+1)'(up);
			lim = {2'b00, Q_MAX[30:0]} + (QW+1)'(l.neg);
			sat = l.ovf || (q1 > lim);
			if (sat) any_sat = 1'b1;
			if (!dv_s[QW].use_div) res_val[c] = dv_s[QW].rnd[c];
			else if (sat)          res_val[c] = l.neg ? Q_MIN : Q_MAX;
			else                   res_val[c] = l.neg ? (32'h0 - q1[31:0]) : q1[31:0];
		end
		if (dv_s[QW].use_div) res_st = any_sat ? ST_SAT : ST_OK;
		else                  res_st = dv_s[QW].pst;
	end

	// ---------------- output register and skid ----------------
	logic [2:0][31:0] out_val_q, skid_val_q;
	logic [1:0]       out_st_q, skid_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || take) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || take) begin
			if (skid_v_q) begin
				out_val_q <= skid_val_q;
				out_st_q  <= skid_st_q;
			end else if (push) begin
				out_val_q <= res_val;
				out_st_q  <= res_st;
			end
		end else if (push) begin
			skid_val_q <= res_val;
			skid_st_q  <= res_st;
		end
	end

	assign vtx_out.valid  = out_v_q;
	assign vtx_out.rx     = out_val_q[0];
	assign vtx_out.ry     = out_val_q[1];
	assign vtx_out.rz     = out_val_q[2];
	assign vtx_out.status = out_st_q;

`ifndef SYNTHESIS
	// items in flight change only by an accept or a delivery
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		!(vtx_in.valid && en) && !take
		|=> ($countones(vld_s) + out_v_q + skid_v_q)
		    == $past($countones(vld_s) + out_v_q + skid_v_q))
		else $error("item count changed without handshake");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_st_q == ST_OK || out_st_q == ST_SAT || out_st_q == ST_WZERO))
		else $error("undefined status code");

	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_st_q == ST_WZERO |->
		(out_val_q[0] == 32'h0 || out_val_q[0] == Q_MAX || out_val_q[0] == Q_MIN))
		else $error("zero w result not saturated");

	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds item ahead of output");
`endif
endmodule
